>>> rtl/core/mbd_pkg.sv
// Shared types and constants of the message batch deframer.
// Item structs for both channels, result kind codes and parameter defaults.
// No dependencies.
package mbd_pkg;

  localparam int unsigned HeaderBytesDef = 8;
  localparam int unsigned IdBytesDef     = 2;

  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_DESC    = 2'd1;
  localparam logic [1:0] KIND_PAYLOAD = 2'd2;
  localparam logic [1:0] KIND_END     = 2'd3;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_TRUNCATED = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_last;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  byte_value;
    logic [5:0]  header_position;
    logic [7:0]  channel_code;
    logic [15:0] message_id;
    logic [15:0] payload_length;
    logic [15:0] message_number;
    logic        status;
    logic        run_last;
  } out_item_t;

endpackage

>>> rtl/core/mbd_stream_if.sv
// Valid/ready stream channel carrying one item per transfer.
// Payload type is a parameter; the deframer uses the structs in mbd_pkg.
interface mbd_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/core/message_batch_deframer_core.sv
// Deframer for length-prefixed message batches: header, count, messages.
// Depends on mbd_pkg (item types, kind codes) and mbd_stream_if.
//
// Channel  Dir  Payload     Transfer
// in_i     in   in_item_t   one packet byte, packet_last on the final byte
// out_o    out  out_item_t  header byte, descriptor, payload byte or packet end
//
// One input byte is taken per cycle while in_i.ready is high; its results land
// in a three-entry result queue in the same clock edge and leave one per cycle
// while out_o.ready is high. A packet's final byte that also yields a header,
// descriptor or payload result yields two results, which the queue absorbs.
// in_i.ready drops only while fewer than two queue entries would be free.
// Reset returns the parser to the header phase and empties the queue.
module message_batch_deframer_core
  import mbd_pkg::*;
#(
  parameter int unsigned HEADER_BYTES = HeaderBytesDef,
  parameter int unsigned ID_BYTES     = IdBytesDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  mbd_stream_if.sink   in_i,
  mbd_stream_if.source out_o
);

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_COUNT   = 3'd1,
    PH_CHANNEL = 3'd2,
    PH_ID      = 3'd3,
    PH_LEN     = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_DONE    = 3'd6
  } phase_e;

  localparam logic [5:0] HdrLastIdx = 6'(HEADER_BYTES - 1);
  localparam logic [5:0] IdLastIdx  = 6'(ID_BYTES - 1);
  localparam int unsigned QDepth    = 3;

  phase_e      phase_q, phase_d;
  logic [5:0]  fc_q, fc_d;
  logic [15:0] msgs_left_q, msgs_left_d;
  logic [15:0] ordinal_q, ordinal_d;
  logic [15:0] pay_left_q, pay_left_d;
  logic [7:0]  chan_q, chan_d;
  logic [15:0] id_q, id_d;
  logic [7:0]  low_q, low_d;
  logic [15:0] cur_len_q, cur_len_d;

  out_item_t   slot_q [QDepth];
  out_item_t   slot_d [QDepth];
  logic [1:0]  count_q, count_d;

  logic        pop, accept;
  logic [1:0]  count_after_pop;
  logic [1:0]  nres;
  out_item_t   pri, fin, res0, res1;
  logic        pri_v;
  logic [7:0]  b;
  logic [15:0] word;

  assign pop             = (count_q != 2'd0) && out_o.ready;
  assign count_after_pop = count_q - {1'b0, pop};
  assign in_i.ready      = !count_after_pop[1];
  assign accept          = in_i.valid && in_i.ready;
  assign out_o.valid     = (count_q != 2'd0);
  assign out_o.payload   = slot_q[0];

  assign b    = in_i.payload.data_byte;
  assign word = {b, low_q};

  // Parse one byte.
  always_comb begin
    phase_d     = phase_q;
    fc_d        = fc_q;
    msgs_left_d = msgs_left_q;
    ordinal_d   = ordinal_q;
    pay_left_d  = pay_left_q;
    chan_d      = chan_q;
    id_d        = id_q;
    low_d       = low_q;
    cur_len_d   = cur_len_q;
    pri         = '0;
    pri_v       = 1'b0;
    fin         = '0;

    case (phase_q)
      PH_HEADER: begin
        pri.kind            = KIND_HEADER;
        pri.byte_value      = b;
        pri.header_position = fc_q;
        pri_v               = 1'b1;
        if (fc_q >= HdrLastIdx) begin
          phase_d = PH_COUNT;
          fc_d    = '0;
        end else begin
          fc_d = fc_q + 6'd1;
        end
      end
      PH_COUNT: begin
        if (fc_q == 6'd0) begin
          low_d = b;
          fc_d  = 6'd1;
        end else begin
          msgs_left_d = word;
          ordinal_d   = '0;
          fc_d        = '0;
          phase_d     = (word == 16'd0) ? PH_DONE : PH_CHANNEL;
        end
      end
      PH_CHANNEL: begin
        chan_d  = b;
        id_d    = '0;
        fc_d    = '0;
        phase_d = PH_ID;
      end
      PH_ID: begin
        if (fc_q[0]) begin
          id_d = id_q | {b, 8'h00};
        end else begin
          id_d = id_q | {8'h00, b};
        end
        if (fc_q >= IdLastIdx) begin
          fc_d    = '0;
          phase_d = PH_LEN;
        end else begin
          fc_d = fc_q + 6'd1;
        end
      end
      PH_LEN: begin
        if (fc_q == 6'd0) begin
          low_d = b;
          fc_d  = 6'd1;
        end else begin
          cur_len_d          = word;
          pay_left_d         = word;
          fc_d               = '0;
          pri.kind           = KIND_DESC;
          pri.channel_code   = chan_q;
          pri.message_id     = id_q;
          pri.payload_length = word;
          pri.message_number = ordinal_q;
          pri_v              = 1'b1;
          if (word == 16'd0) begin
            ordinal_d   = ordinal_q + 16'd1;
            msgs_left_d = msgs_left_q - 16'd1;
            phase_d     = (msgs_left_q == 16'd1) ? PH_DONE : PH_CHANNEL;
          end else begin
            phase_d = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        pri.kind           = KIND_PAYLOAD;
        pri.byte_value     = b;
        pri.channel_code   = chan_q;
        pri.message_id     = id_q;
        pri.payload_length = cur_len_q;
        pri.message_number = ordinal_q;
        pri_v              = 1'b1;
        pay_left_d         = pay_left_q - 16'd1;
        if (pay_left_q == 16'd1) begin
          ordinal_d   = ordinal_q + 16'd1;
          msgs_left_d = msgs_left_q - 16'd1;
          phase_d     = (msgs_left_q == 16'd1) ? PH_DONE : PH_CHANNEL;
          fc_d        = '0;
        end
      end
      default: begin
        // trailing bytes: drop
      end
    endcase

    fin.kind     = KIND_END;
    fin.status   = (phase_d == PH_DONE) ? STATUS_OK : STATUS_TRUNCATED;
    fin.run_last = 1'b1;

    if (in_i.payload.packet_last) begin
      phase_d     = PH_HEADER;
      fc_d        = '0;
      msgs_left_d = '0;
      ordinal_d   = '0;
      pay_left_d  = '0;
      chan_d      = '0;
      id_d        = '0;
      low_d       = '0;
      cur_len_d   = '0;
    end
  end

  // Order the results of this byte.
  always_comb begin
    res0 = pri;
    res1 = fin;
    nres = 2'd0;
    if (pri_v && in_i.payload.packet_last) begin
      nres = 2'd2;
    end else if (pri_v) begin
      res0.run_last = 1'b1;
      nres          = 2'd1;
    end else if (in_i.payload.packet_last) begin
      res0 = fin;
      nres = 2'd1;
    end
  end

  // Result queue: shift on pop, append after the surviving entries.
  always_comb begin
    for (int i = 0; i < QDepth; i++) begin
      if (pop && (i < QDepth - 1)) begin
        slot_d[i] = slot_q[(i + 1) % QDepth];
      end else begin
        slot_d[i] = slot_q[i];
      end
      if (accept && (nres != 2'd0) && (2'(i) == count_after_pop)) begin
        slot_d[i] = res0;
      end else if (accept && (nres == 2'd2) && (2'(i) == count_after_pop + 2'd1)) begin
        slot_d[i] = res1;
      end
    end
    count_d = accept ? count_after_pop + nres : count_after_pop;
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      phase_q     <= PH_HEADER;
      fc_q        <= '0;
      msgs_left_q <= '0;
      ordinal_q   <= '0;
      pay_left_q  <= '0;
      chan_q      <= '0;
      id_q        <= '0;
      low_q       <= '0;
      cur_len_q   <= '0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        phase_q     <= phase_d;
        fc_q        <= fc_d;
        msgs_left_q <= msgs_left_d;
        ordinal_q   <= ordinal_d;
        pay_left_q  <= pay_left_d;
        chan_q      <= chan_d;
        id_q        <= id_d;
        low_q       <= low_d;
        cur_len_q   <= cur_len_d;
      end
    end
  end

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_i.payload.packet_last |=> phase_q == PH_HEADER && fc_q == 6'd0)
    else $error("packet end did not return parser to header phase");

  a_header_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_HEADER |-> fc_q <= HdrLastIdx)
    else $error("header index past header size");

  a_payload_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> pay_left_q != 16'd0)
    else $error("payload phase with nothing left");

  a_messages_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_CHANNEL || phase_q == PH_ID || phase_q == PH_LEN) |->
      msgs_left_q != 16'd0)
    else $error("message phase with no messages left");

  a_queue_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd0 || !out_o.valid)
    else $error("result queue shows valid while empty");

endmodule

>>> tb/tb_message_batch_deframer_core.sv
// Self-checking testbench for message_batch_deframer_core: packet bytes in, deframed results out.
// Depends on mbd_pkg and mbd_stream_if; predicts every result and checks it in arrival order.
// Random gaps on both channels; hold-offs drain the block completely before the random packets and mid-run.
module tb_message_batch_deframer_core;
  import mbd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HDR = HeaderBytesDef;
  localparam int unsigned IDB = IdBytesDef;

  typedef enum logic [2:0] {
    ST_HEADER, ST_COUNT, ST_CHANNEL, ST_ID, ST_LEN, ST_PAYLOAD, ST_DONE
  } parse_state_e;

  typedef struct {
    in_item_t item;
    bit       drain;
  } stim_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  mbd_stream_if #(.T(in_item_t))  in_ch ();
  mbd_stream_if #(.T(out_item_t)) out_ch ();

  message_batch_deframer_core #(
    .HEADER_BYTES (HDR),
    .ID_BYTES     (IDB)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  stim_t       pending_bytes[$];
  out_item_t   predicted_results[$];
  bit          drain_next;
  bit          quiet;
  int          mismatches;
  int          sent;
  int unsigned gap_left;
  int unsigned stall_left;

  // Parser state of the prediction
  parse_state_e pstate;
  logic [5:0]   fld_cnt;
  logic [15:0]  msgs_left;
  logic [15:0]  msg_ord;
  logic [15:0]  pay_left;
  logic [15:0]  cur_len;
  logic [15:0]  id_acc;
  logic [7:0]   chan;
  logic [7:0]   low_hold;

  task automatic clear_parser();
    pstate    = ST_HEADER;
    fld_cnt   = '0;
    msgs_left = '0;
    msg_ord   = '0;
    pay_left  = '0;
    cur_len   = '0;
    id_acc    = '0;
    chan      = '0;
    low_hold  = '0;
  endtask

  task automatic close_message();
    msg_ord   = msg_ord + 16'd1;
    msgs_left = msgs_left - 16'd1;
    pstate    = (msgs_left == 16'd0) ? ST_DONE : ST_CHANNEL;
    fld_cnt   = '0;
  endtask

  function automatic out_item_t with_message(out_item_t r);
    r.channel_code   = chan;
    r.message_id     = id_acc;
    r.payload_length = cur_len;
    r.message_number = msg_ord;
    return r;
  endfunction

  // Work out the results of one accepted packet byte and queue them
  task automatic deframe_byte(input in_item_t it);
    out_item_t r;
    out_item_t res[$];
    r = '0;
    case (pstate)
      ST_HEADER: begin
        r.kind            = KIND_HEADER;
        r.byte_value      = it.data_byte;
        r.header_position = fld_cnt;
        res.insert(res.size(), r);
        if (fld_cnt + 1 >= HDR) begin
          pstate  = ST_COUNT;
          fld_cnt = '0;
        end else begin
          fld_cnt = fld_cnt + 6'd1;
        end
      end
      ST_COUNT: begin
        if (fld_cnt == 6'd0) begin
          low_hold = it.data_byte;
          fld_cnt  = 6'd1;
        end else begin
          msgs_left = {it.data_byte, low_hold};
          msg_ord   = '0;
          fld_cnt   = '0;
          pstate    = (msgs_left == 16'd0) ? ST_DONE : ST_CHANNEL;
        end
      end
      ST_CHANNEL: begin
        chan    = it.data_byte;
        id_acc  = '0;
        fld_cnt = '0;
        pstate  = ST_ID;
      end
      ST_ID: begin
        id_acc = id_acc | (16'(it.data_byte) << (8 * fld_cnt[0]));
        if (fld_cnt + 1 >= IDB) begin
          fld_cnt = '0;
          pstate  = ST_LEN;
        end else begin
          fld_cnt = fld_cnt + 6'd1;
        end
      end
      ST_LEN: begin
        if (fld_cnt == 6'd0) begin
          low_hold = it.data_byte;
          fld_cnt  = 6'd1;
        end else begin
          cur_len  = {it.data_byte, low_hold};
          pay_left = cur_len;
          fld_cnt  = '0;
          r.kind   = KIND_DESC;
          res.insert(res.size(), with_message(r));
          if (pay_left == 16'd0) close_message();
          else pstate = ST_PAYLOAD;
        end
      end
      ST_PAYLOAD: begin
        r.kind       = KIND_PAYLOAD;
        r.byte_value = it.data_byte;
        res.insert(res.size(), with_message(r));
        pay_left = pay_left - 16'd1;
        if (pay_left == 16'd0) close_message();
      end
      default: ;  // trailing bytes: nothing to emit
    endcase
    if (it.packet_last) begin
      r        = '0;
      r.kind   = KIND_END;
      r.status = (pstate == ST_DONE) ? STATUS_OK : STATUS_TRUNCATED;
      res.insert(res.size(), r);
      clear_parser();
    end
    if (res.size() != 0) res[res.size() - 1].run_last = 1'b1;
    foreach (res[i]) predicted_results.insert(predicted_results.size(), res[i]);
  endtask

  function automatic string fmt_result(out_item_t r);
    return $sformatf({"kind=%0d byte=%02h pos=%0d chan=%02h id=%04h len=%0d num=%0d",
                      " st=%0b last=%0b"},
                     r.kind, r.byte_value, r.header_position, r.channel_code, r.message_id,
                     r.payload_length, r.message_number, r.status, r.run_last);
  endfunction

  // Mostly short gaps, a few long ones; none during quiet stretches
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic queue_byte(input logic [7:0] b, input logic last);
    stim_t s;
    s.item.data_byte   = b;
    s.item.packet_last = last;
    s.drain            = drain_next;
    drain_next         = 1'b0;
    pending_bytes.insert(pending_bytes.size(), s);
  endtask

  // Header, count, messages; optionally cut short or followed by trailing bytes
  task automatic build_packet(input int n_msgs, input int len_max, input bit wild,
                              input int cut_at, input int n_trail);
    logic [7:0] pkt[$];
    int         limit;
    int         count;
    int         len;
    limit = (cut_at >= 0) ? cut_at + 1 : 32'h7fff_ffff;
    count = wild ? $urandom_range(0, 16'hffff) : n_msgs;
    repeat (HDR) pkt.insert(pkt.size(), 8'($urandom));
    pkt.insert(pkt.size(), count[7:0]);
    pkt.insert(pkt.size(), count[15:8]);
    for (int m = 0; m < count && pkt.size() < limit; m++) begin
      len = wild ? $urandom_range(0, 16'hffff) : $urandom_range(0, len_max);
      pkt.insert(pkt.size(), 8'($urandom));
      repeat (IDB) pkt.insert(pkt.size(), 8'($urandom));
      pkt.insert(pkt.size(), len[7:0]);
      pkt.insert(pkt.size(), len[15:8]);
      for (int j = 0; j < len && pkt.size() < limit; j++) pkt.insert(pkt.size(), 8'($urandom));
    end
    if (cut_at >= 0) begin
      while (pkt.size() > limit) void'(pkt.pop_back());
    end else begin
      repeat (n_trail) pkt.insert(pkt.size(), 8'($urandom));
    end
    foreach (pkt[i]) queue_byte(pkt[i], i == pkt.size() - 1);
  endtask

  // Driver: advance to the next byte once the current one has transferred
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (gap_left != 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (pending_bytes.size() != 0 &&
                   !(pending_bytes[0].drain &&
                     (in_ch.valid || predicted_results.size() != 0))) begin
        in_ch.valid   <= 1'b1;
        in_ch.payload <= pending_bytes[0].item;
        void'(pending_bytes.pop_front());
        sent++;
        quiet    = ((sent / 150) % 4) == 3;
        gap_left = pick_gap();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      stall_left = pick_gap();
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Monitor: predict on input transfers, check on output transfers
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) deframe_byte(in_ch.payload);
      if (out_ch.valid && out_ch.ready) begin
        if (predicted_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: %s", fmt_result(out_ch.payload));
        end else begin
          want = predicted_results.pop_front();
          if (out_ch.payload !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: expected %s", fmt_result(want));
              $display("          actual   %s", fmt_result(out_ch.payload));
            end
          end
        end
      end
    end
  end

  initial begin
    int sel;
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    out_ch.ready  = 1'b0;
    clear_parser();

    // Header cut short on its very first byte
    queue_byte(8'h00, 1'b1);
    // Zero messages, then one trailing byte carrying the end
    repeat (HDR) queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b1);
    // One message with empty payload, packet ends on its length
    for (int i = 0; i < HDR; i++) queue_byte(8'(i * 37), 1'b0);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    repeat (IDB) queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b1);

    drain_next = 1'b1;
    while (pending_bytes.size() < 1030) begin
      if (pending_bytes.size() > 500 && pending_bytes.size() < 520) drain_next = 1'b1;
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
        build_packet($urandom_range(0, 4), ($urandom_range(0, 9) == 0) ? 40 : 6, 1'b0, -1,
                     ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 3));
      end else if (sel < 80) begin
        build_packet($urandom_range(1, 4), 6, 1'b0, $urandom_range(0, 40), 0);
      end else if (sel < 90) begin
        build_packet(0, 0, 1'b1, $urandom_range(0, 30), 0);
      end else begin
        // noise, closed by an end so that following packets line up again
        repeat ($urandom_range(0, 11)) queue_byte(8'($urandom), $urandom_range(0, 3) == 0);
        queue_byte(8'($urandom), 1'b1);
      end
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    do @(posedge clk_i); while (pending_bytes.size() != 0 || in_ch.valid);
    while (predicted_results.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    if (mismatches == 0 && predicted_results.size() == 0) begin
      $display("PASS message_batch_deframer_core");
    end else begin
      $display("FAIL message_batch_deframer_core");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAIL message_batch_deframer_core");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/mbd_pkg.sv
rtl/core/mbd_stream_if.sv
rtl/core/message_batch_deframer_core.sv
tb/tb_message_batch_deframer_core.sv
